[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the framer RTL.
// Each macro expects clock aclk and active-low reset aresetn in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/bsfb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfb_pkg
// Types, register map and constants of the byte-stuffed frame builder.
// ----------------------------------------------------------------------------
package bsfb_pkg;

    localparam int unsigned ADDR_W      = 5;
    localparam int unsigned REG_IDX_W   = 3;
    localparam int unsigned DATA_W      = 32;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [REG_IDX_W-1:0] REG_FLAG    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ESCAPE  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_MASK    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ADDRESS = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_CTRL0   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_CTRL1   = 3'd5;

    localparam logic [7:0] RST_FLAG    = 8'd126;
    localparam logic [7:0] RST_ESCAPE  = 8'd125;
    localparam logic [7:0] RST_MASK    = 8'd32;
    localparam logic [7:0] RST_ADDRESS = 8'd3;
    localparam logic [7:0] RST_CTRL0   = 8'd0;
    localparam logic [7:0] RST_CTRL1   = 8'd64;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] line_byte;
        logic       run_end;
        logic       frame_end;
    } out_item_t;

    typedef struct packed {
        logic [7:0] flag_byte;
        logic [7:0] escape_byte;
        logic [7:0] stuff_mask;
        logic [7:0] address_byte;
        logic [7:0] control_zero;
        logic [7:0] control_one;
    } cfg_t;

    // One classified payload byte, handed from the front end to the emitter.
    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
        logic       seq;
        logic [7:0] check;
    } job_t;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_FLAG,
        PH_ADDR,
        PH_CTRL,
        PH_HCHK,
        PH_DATA,
        PH_DATA_X,
        PH_PCHK,
        PH_PCHK_X,
        PH_CLOSE
    } phase_t;

endpackage

[rtl/byte_stuffed_frame_builder_core.sv]
`timescale 1ns / 1ps
// With the emitter idle, a byte accepted on s_ is written into the job queue and then
//   into the output register, where its first line byte shows on m_.
// Throughput: one line byte per cycle from the emitter while m_ready does not stall it;
//   a byte causes 1 to 9 line bytes (1 for a plain byte mid-frame).
// Reset (aresetn low, synchronous) empties the 2-entry job queue and the output, restores
//   the register defaults and clears the sequence bit and payload check.
// ----------------------------------------------------------------------------
// byte_stuffed_frame_builder_core
// HDLC-style framer with byte stuffing and an APB-style register port.
// ----------------------------------------------------------------------------
module byte_stuffed_frame_builder_core #(
    parameter int unsigned QUEUE_DEPTH = bsfb_pkg::QUEUE_DEPTH
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  bsfb_pkg::in_item_t              s_payload,
    output logic                            m_valid,
    input  logic                            m_ready,
    output bsfb_pkg::out_item_t             m_payload,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bsfb_pkg::ADDR_W-1:0]     paddr,
    input  logic [bsfb_pkg::DATA_W-1:0]     pwdata,
    output logic [bsfb_pkg::DATA_W-1:0]     prdata,
    output logic                            pready
);

    bsfb_pkg::cfg_t cfg_reg;
    bsfb_pkg::cfg_t cfg_next;

    logic                              wr_en;
    logic [bsfb_pkg::REG_IDX_W-1:0]    reg_idx;
    logic [7:0]                        rd_byte;

    logic           push;
    bsfb_pkg::job_t push_job;
    logic           q_ready;
    logic           pop;
    logic           head_valid;
    bsfb_pkg::job_t head_job;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[bsfb_pkg::ADDR_W-1:2];

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx)
                bsfb_pkg::REG_FLAG:    cfg_next.flag_byte    = pwdata[7:0];
                bsfb_pkg::REG_ESCAPE:  cfg_next.escape_byte  = pwdata[7:0];
                bsfb_pkg::REG_MASK:    cfg_next.stuff_mask   = pwdata[7:0];
                bsfb_pkg::REG_ADDRESS: cfg_next.address_byte = pwdata[7:0];
                bsfb_pkg::REG_CTRL0:   cfg_next.control_zero = pwdata[7:0];
                bsfb_pkg::REG_CTRL1:   cfg_next.control_one  = pwdata[7:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            bsfb_pkg::REG_FLAG:    rd_byte = cfg_reg.flag_byte;
            bsfb_pkg::REG_ESCAPE:  rd_byte = cfg_reg.escape_byte;
            bsfb_pkg::REG_MASK:    rd_byte = cfg_reg.stuff_mask;
            bsfb_pkg::REG_ADDRESS: rd_byte = cfg_reg.address_byte;
            bsfb_pkg::REG_CTRL0:   rd_byte = cfg_reg.control_zero;
            bsfb_pkg::REG_CTRL1:   rd_byte = cfg_reg.control_one;
            default:               rd_byte = 8'd0;
        endcase
    end

    assign prdata = {{(bsfb_pkg::DATA_W - 8){1'b0}}, rd_byte};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.flag_byte    <= bsfb_pkg::RST_FLAG;
            cfg_reg.escape_byte  <= bsfb_pkg::RST_ESCAPE;
            cfg_reg.stuff_mask   <= bsfb_pkg::RST_MASK;
            cfg_reg.address_byte <= bsfb_pkg::RST_ADDRESS;
            cfg_reg.control_zero <= bsfb_pkg::RST_CTRL0;
            cfg_reg.control_one  <= bsfb_pkg::RST_CTRL1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    bsfb_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .q_ready   (q_ready),
        .push      (push),
        .push_job  (push_job)
    );

    bsfb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_job   (push_job),
        .in_ready   (q_ready),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    bsfb_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_payload  (m_payload)
    );

endmodule

[rtl/bsfb_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfb_front
// Accepts payload bytes, tracks the sequence bit and the running payload
// check, and pushes one job per byte into the job queue.
// ----------------------------------------------------------------------------
module bsfb_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  bsfb_pkg::in_item_t s_payload,
    input  logic              q_ready,
    output logic              push,
    output bsfb_pkg::job_t    push_job
);

    logic       seq_reg;
    logic       seq_next;
    logic [7:0] check_reg;
    logic [7:0] check_next;
    logic [7:0] check_base;
    logic [7:0] check_new;
    logic       accept;

    assign s_ready = q_ready;
    assign accept  = s_valid && q_ready;
    assign push    = accept;

    // A first byte restarts the check from this byte.
    assign check_base = s_payload.first_byte ? 8'd0 : check_reg;
    assign check_new  = check_base ^ s_payload.data_byte;

    always_comb begin
        push_job.data  = s_payload.data_byte;
        push_job.first = s_payload.first_byte;
        push_job.last  = s_payload.last_byte;
        push_job.seq   = seq_reg ^ s_payload.first_byte;
        push_job.check = check_new;
    end

    always_comb begin
        seq_next   = seq_reg;
        check_next = check_reg;
        if (accept) begin
            seq_next   = push_job.seq;
            check_next = s_payload.last_byte ? 8'd0 : check_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg   <= 1'b0;
            check_reg <= 8'd0;
        end else begin
            seq_reg   <= seq_next;
            check_reg <= check_next;
        end
    end

endmodule

[rtl/bsfb_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfb_queue
// Small job FIFO between the front end and the emitter.
// ----------------------------------------------------------------------------
module bsfb_queue #(
    parameter int unsigned DEPTH = bsfb_pkg::QUEUE_DEPTH
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  bsfb_pkg::job_t push_job,
    output logic           in_ready,
    input  logic           pop,
    output logic           head_valid,
    output bsfb_pkg::job_t head_job
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    bsfb_pkg::job_t entry_reg [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign in_ready   = (count_reg != CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

[rtl/bsfb_back.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// bsfb_back
// Emitter: walks the head job through header (first byte only), stuffed payload,
// stuffed check and closing flag (last byte only), one line byte per cycle
// into the output register while it is empty or m_ready takes its byte.
module bsfb_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  bsfb_pkg::cfg_t      cfg,
    input  logic                head_valid,
    input  bsfb_pkg::job_t      head_job,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output bsfb_pkg::out_item_t m_payload
);

    bsfb_pkg::phase_t phase_reg;
    bsfb_pkg::phase_t phase_next;
    bsfb_pkg::phase_t eff_phase;

    logic                m_valid_reg;
    logic                m_valid_next;
    bsfb_pkg::out_item_t m_payload_reg;
    bsfb_pkg::out_item_t m_payload_next;

    logic       step;
    logic       job_done;
    logic       data_stuff;
    logic       chk_stuff;
    logic [7:0] ctrl;
    logic [7:0] out_byte;
    logic       out_fend;

    assign ctrl       = head_job.seq ? cfg.control_one : cfg.control_zero;
    assign data_stuff = (head_job.data == cfg.flag_byte) || (head_job.data == cfg.escape_byte);
    assign chk_stuff  = (head_job.check == cfg.flag_byte)
                        || (head_job.check == cfg.escape_byte);

    // A job that has not started yet begins at the header or at the payload.
    always_comb begin
        if (phase_reg == bsfb_pkg::PH_IDLE) begin
            eff_phase = head_job.first ? bsfb_pkg::PH_FLAG : bsfb_pkg::PH_DATA;
        end else begin
            eff_phase = phase_reg;
        end
    end

    assign step = head_valid && (!m_valid_reg || m_ready);
    assign pop  = step && job_done;

    // Next phase.
    always_comb begin
        phase_next = phase_reg;
        if (step) begin
            case (eff_phase)
                bsfb_pkg::PH_FLAG: phase_next = bsfb_pkg::PH_ADDR;
                bsfb_pkg::PH_ADDR: phase_next = bsfb_pkg::PH_CTRL;
                bsfb_pkg::PH_CTRL: phase_next = bsfb_pkg::PH_HCHK;
                bsfb_pkg::PH_HCHK: phase_next = bsfb_pkg::PH_DATA;
                bsfb_pkg::PH_DATA: begin
                    if (data_stuff) begin
                        phase_next = bsfb_pkg::PH_DATA_X;
                    end else if (head_job.last) begin
                        phase_next = bsfb_pkg::PH_PCHK;
                    end else begin
                        phase_next = bsfb_pkg::PH_IDLE;
                    end
                end
                bsfb_pkg::PH_DATA_X: begin
                    phase_next = head_job.last ? bsfb_pkg::PH_PCHK : bsfb_pkg::PH_IDLE;
                end
                bsfb_pkg::PH_PCHK: begin
                    phase_next = chk_stuff ? bsfb_pkg::PH_PCHK_X : bsfb_pkg::PH_CLOSE;
                end
                bsfb_pkg::PH_PCHK_X: phase_next = bsfb_pkg::PH_CLOSE;
                bsfb_pkg::PH_CLOSE:  phase_next = bsfb_pkg::PH_IDLE;
                default:             phase_next = bsfb_pkg::PH_IDLE;
            endcase
        end
    end

    // Byte selection for the current phase.
    always_comb begin
        out_byte = cfg.flag_byte;
        out_fend = 1'b0;
        job_done = 1'b0;
        case (eff_phase)
            bsfb_pkg::PH_FLAG: out_byte = cfg.flag_byte;
            bsfb_pkg::PH_ADDR: out_byte = cfg.address_byte;
            bsfb_pkg::PH_CTRL: out_byte = ctrl;
            bsfb_pkg::PH_HCHK: out_byte = cfg.address_byte ^ ctrl;
            bsfb_pkg::PH_DATA: begin
                out_byte = data_stuff ? cfg.escape_byte : head_job.data;
                job_done = !data_stuff && !head_job.last;
            end
            bsfb_pkg::PH_DATA_X: begin
                out_byte = head_job.data ^ cfg.stuff_mask;
                job_done = !head_job.last;
            end
            bsfb_pkg::PH_PCHK: out_byte = chk_stuff ? cfg.escape_byte : head_job.check;
            bsfb_pkg::PH_PCHK_X: out_byte = head_job.check ^ cfg.stuff_mask;
            bsfb_pkg::PH_CLOSE: begin
                out_byte = cfg.flag_byte;
                out_fend = 1'b1;
                job_done = 1'b1;
            end
            default: out_byte = cfg.flag_byte;
        endcase
    end

    always_comb begin
        m_valid_next   = m_valid_reg;
        m_payload_next = m_payload_reg;
        if (step) begin
            m_valid_next             = 1'b1;
            m_payload_next.line_byte = out_byte;
            m_payload_next.run_end   = job_done;
            m_payload_next.frame_end = out_fend;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= bsfb_pkg::PH_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_payload_reg <= m_payload_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    `ASSERT_IMPLIES(a_close_ends_run, m_valid_reg && m_payload_reg.frame_end, m_payload_reg.run_end, "closing flag without end of run")
    `ASSERT_IMPLIES(a_job_held, phase_reg != bsfb_pkg::PH_IDLE, head_valid, "job in progress left the queue")
    `ASSERT_NEXT(a_job_continues, step && !job_done, phase_reg != bsfb_pkg::PH_IDLE, "unfinished job lost its phase")

endmodule
